// ----- rtl/mps_pkg.sv -----
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types, constants and the microcode table of the modular power sum.
// ----------------------------------------------------------------------------
package mps_pkg;

   localparam int MOD_WIDTH              = 16;
   localparam int COUNT_WIDTH_DEFAULT    = 16;
   localparam int EXPONENT_WIDTH_DEFAULT = 32;
   localparam int STEP_WIDTH             = 5;

   localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = 16'd49999;

   typedef logic [STEP_WIDTH-1:0] step_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_INC_K,
      OP_START_KMOD,
      OP_LOAD_SB,
      OP_START_PP,
      OP_LOAD_PP,
      OP_START_SQ,
      OP_LOAD_SB_SHIFT,
      OP_ACC_ADD,
      OP_RESULT
   } op_type;

   typedef enum logic [3:0] {
      JMP_NEVER,
      JMP_ALWAYS,
      JMP_NO_REQ,
      JMP_M_SMALL,
      JMP_K_EQ_N,
      JMP_BUSY,
      JMP_ES_ZERO,
      JMP_ES_EVEN,
      JMP_RSP_BLOCKED
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } uword_type;

   typedef struct packed {
      logic req_valid;
      logic m_small;
      logic k_eq_n;
      logic busy;
      logic es_zero;
      logic es_even;
      logic rsp_blocked;
   } status_type;

   localparam step_type STEP_IDLE = 5'd0;
   localparam step_type STEP_HEAD = 5'd2;
   localparam step_type STEP_EXP  = 5'd7;
   localparam step_type STEP_SQ   = 5'd12;
   localparam step_type STEP_ACC  = 5'd15;
   localparam step_type STEP_DONE = 5'd16;

   function automatic uword_type uw(op_type op, cond_type cond, step_type target);
      uword_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // program: for k in 1..n { sb = k mod m; pp = 1; square-and-multiply; acc += pp }
   function automatic uword_type ucode(step_type s);
      uword_type w;
      case (s)
         5'd0:    w = uw(OP_NOP,           JMP_NO_REQ,      STEP_IDLE);
         5'd1:    w = uw(OP_NOP,           JMP_M_SMALL,     STEP_DONE);
         5'd2:    w = uw(OP_NOP,           JMP_K_EQ_N,      STEP_DONE);
         5'd3:    w = uw(OP_INC_K,         JMP_NEVER,       STEP_IDLE);
         5'd4:    w = uw(OP_START_KMOD,    JMP_NEVER,       STEP_IDLE);
         5'd5:    w = uw(OP_NOP,           JMP_BUSY,        5'd5);
         5'd6:    w = uw(OP_LOAD_SB,       JMP_NEVER,       STEP_IDLE);
         5'd7:    w = uw(OP_NOP,           JMP_ES_ZERO,     STEP_ACC);
         5'd8:    w = uw(OP_NOP,           JMP_ES_EVEN,     STEP_SQ);
         5'd9:    w = uw(OP_START_PP,      JMP_NEVER,       STEP_IDLE);
         5'd10:   w = uw(OP_NOP,           JMP_BUSY,        5'd10);
         5'd11:   w = uw(OP_LOAD_PP,       JMP_NEVER,       STEP_IDLE);
         5'd12:   w = uw(OP_START_SQ,      JMP_NEVER,       STEP_IDLE);
         5'd13:   w = uw(OP_NOP,           JMP_BUSY,        5'd13);
         5'd14:   w = uw(OP_LOAD_SB_SHIFT, JMP_ALWAYS,      STEP_EXP);
         5'd15:   w = uw(OP_ACC_ADD,       JMP_ALWAYS,      STEP_HEAD);
         5'd16:   w = uw(OP_RESULT,        JMP_RSP_BLOCKED, STEP_DONE);
         5'd17:   w = uw(OP_NOP,           JMP_ALWAYS,      STEP_IDLE);
         default: w = uw(OP_NOP,           JMP_ALWAYS,      STEP_IDLE);
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/mps_modmul.sv -----
// ----------------------------------------------------------------------------
// mps_modmul
// Bit-serial modular multiplier: result = addend * multiplier mod modulus,
// one multiplier bit per cycle, MSB first. Addend must be below the modulus.
// ----------------------------------------------------------------------------
module mps_modmul #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mps_pkg::MOD_WIDTH-1:0] addend,
   input  logic [OPERAND_WIDTH-1:0]      multiplier,
   input  logic [mps_pkg::MOD_WIDTH-1:0] modulus,
   output logic                          busy,
   output logic [mps_pkg::MOD_WIDTH-1:0] result
);
   import mps_pkg::*;

   localparam int CNT_WIDTH = $clog2(OPERAND_WIDTH);
   localparam int SUM_WIDTH = MOD_WIDTH + 2;

   logic                     busy_ff, busy_in;
   logic [CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [MOD_WIDTH-1:0]     rem_ff, rem_in;
   logic [MOD_WIDTH-1:0]     addend_ff, addend_in;
   logic [OPERAND_WIDTH-1:0] mult_ff, mult_in;

   logic [SUM_WIDTH-1:0] mod_ext, dbl, sub1, sub2;

   always_comb begin
      mod_ext = SUM_WIDTH'(modulus);
      dbl     = {1'b0, rem_ff, 1'b0}
                + (mult_ff[OPERAND_WIDTH-1] ? SUM_WIDTH'(addend_ff) : '0);
      sub1    = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
      sub2    = (sub1 >= mod_ext) ? sub1 - mod_ext : sub1;

      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      addend_in = addend_ff;
      mult_in   = mult_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         rem_in    = '0;
         addend_in = addend;
         mult_in   = multiplier;
      end else if (busy_ff) begin
         rem_in  = sub2[MOD_WIDTH-1:0];
         mult_in = {mult_ff[OPERAND_WIDTH-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(OPERAND_WIDTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff    <= rem_in;
      addend_ff <= addend_in;
      mult_ff   <= mult_in;
   end

   assign busy   = busy_ff;
   assign result = rem_ff;

endmodule

// ----- rtl/mps_datapath.sv -----
// ----------------------------------------------------------------------------
// mps_datapath
// Working registers, modulus register, output register and the modular
// multiplier, driven by one micro-op per cycle.
// ----------------------------------------------------------------------------
module mps_datapath #(
   parameter int COUNT_WIDTH    = mps_pkg::COUNT_WIDTH_DEFAULT,
   parameter int EXPONENT_WIDTH = mps_pkg::EXPONENT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mps_pkg::op_type               op,
   input  logic                          idle,
   output mps_pkg::status_type           status,
   input  logic                          csr_we,
   input  logic [mps_pkg::MOD_WIDTH-1:0] csr_wdata,
   input  logic                          req_valid,
   input  logic [COUNT_WIDTH-1:0]        req_term_count,
   input  logic [EXPONENT_WIDTH-1:0]     req_exponent,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mps_pkg::MOD_WIDTH-1:0] rsp_power_sum
);
   import mps_pkg::*;

   localparam int OPERAND_WIDTH = (COUNT_WIDTH > MOD_WIDTH) ? COUNT_WIDTH : MOD_WIDTH;

   logic [MOD_WIDTH-1:0]      modulus_ff, modulus_in;
   logic [COUNT_WIDTH-1:0]    term_count_ff, term_count_in;
   logic [EXPONENT_WIDTH-1:0] exponent_ff, exponent_in;
   logic [COUNT_WIDTH-1:0]    base_index_ff, base_index_in;
   logic [MOD_WIDTH-1:0]      accumulator_ff, accumulator_in;
   logic [MOD_WIDTH-1:0]      partial_power_ff, partial_power_in;
   logic [MOD_WIDTH-1:0]      squared_base_ff, squared_base_in;
   logic [EXPONENT_WIDTH-1:0] exponent_shift_ff, exponent_shift_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [MOD_WIDTH-1:0]      rsp_power_sum_ff, rsp_power_sum_in;

   logic                     accept;
   logic                     rsp_blocked;
   logic                     mul_start;
   logic                     mul_busy;
   logic [MOD_WIDTH-1:0]     mul_addend;
   logic [OPERAND_WIDTH-1:0] mul_multiplier;
   logic [MOD_WIDTH-1:0]     mul_result;
   logic [MOD_WIDTH:0]       acc_sum;

   assign accept      = idle && req_valid;
   assign rsp_blocked = rsp_valid_ff && rsp_stall;

   always_comb begin
      mul_start      = 1'b0;
      mul_addend     = squared_base_ff;
      mul_multiplier = OPERAND_WIDTH'(squared_base_ff);
      case (op)
         OP_START_KMOD: begin
            mul_start      = 1'b1;
            mul_addend     = MOD_WIDTH'(1);
            mul_multiplier = OPERAND_WIDTH'(base_index_ff);
         end
         OP_START_PP: begin
            mul_start  = 1'b1;
            mul_addend = partial_power_ff;
         end
         OP_START_SQ: begin
            mul_start = 1'b1;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   mps_modmul #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_modmul (
      .clock      (clock),
      .reset      (reset),
      .start      (mul_start),
      .addend     (mul_addend),
      .multiplier (mul_multiplier),
      .modulus    (modulus_ff),
      .busy       (mul_busy),
      .result     (mul_result)
   );

   always_comb begin
      acc_sum = {1'b0, accumulator_ff} + {1'b0, partial_power_ff};

      modulus_in        = csr_we ? csr_wdata : modulus_ff;
      term_count_in     = term_count_ff;
      exponent_in       = exponent_ff;
      base_index_in     = base_index_ff;
      accumulator_in    = accumulator_ff;
      partial_power_in  = partial_power_ff;
      squared_base_in   = squared_base_ff;
      exponent_shift_in = exponent_shift_ff;
      rsp_valid_in      = rsp_blocked;
      rsp_power_sum_in  = rsp_power_sum_ff;

      if (accept) begin
         term_count_in  = req_term_count;
         exponent_in    = req_exponent;
         base_index_in  = '0;
         accumulator_in = '0;
      end

      case (op)
         OP_INC_K: begin
            base_index_in = base_index_ff + 1'b1;
         end
         OP_START_KMOD: begin
            partial_power_in  = MOD_WIDTH'(1);
            exponent_shift_in = exponent_ff;
         end
         OP_LOAD_SB: begin
            squared_base_in = mul_result;
         end
         OP_LOAD_PP: begin
            partial_power_in = mul_result;
         end
         OP_LOAD_SB_SHIFT: begin
            squared_base_in   = mul_result;
            exponent_shift_in = exponent_shift_ff >> 1;
         end
         OP_ACC_ADD: begin
            accumulator_in = (acc_sum >= {1'b0, modulus_ff})
                             ? MOD_WIDTH'(acc_sum - {1'b0, modulus_ff})
                             : acc_sum[MOD_WIDTH-1:0];
         end
         OP_RESULT: begin
            if (!rsp_blocked) begin
               rsp_valid_in     = 1'b1;
               rsp_power_sum_in = accumulator_ff;
            end
         end
         default: begin
            base_index_in = base_index_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MODULUS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      term_count_ff     <= term_count_in;
      exponent_ff       <= exponent_in;
      base_index_ff     <= base_index_in;
      accumulator_ff    <= accumulator_in;
      partial_power_ff  <= partial_power_in;
      squared_base_ff   <= squared_base_in;
      exponent_shift_ff <= exponent_shift_in;
      rsp_power_sum_ff  <= rsp_power_sum_in;
   end

   always_comb begin
      status.req_valid   = req_valid;
      status.m_small     = modulus_ff < MOD_WIDTH'(2);
      status.k_eq_n      = base_index_ff == term_count_ff;
      status.busy        = mul_busy;
      status.es_zero     = exponent_shift_ff == '0;
      status.es_even     = !exponent_shift_ff[0];
      status.rsp_blocked = rsp_blocked;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_power_sum = rsp_power_sum_ff;

endmodule

// ----- rtl/mps_sequencer.sv -----
// ----------------------------------------------------------------------------
// mps_sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module mps_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  mps_pkg::status_type status,
   output mps_pkg::op_type     op,
   output logic                idle
);
   import mps_pkg::*;

   step_type  step_ff, step_in;
   uword_type word;
   logic      take;

   always_comb begin
      word = ucode(step_ff);
      case (word.cond)
         JMP_NEVER:       take = 1'b0;
         JMP_ALWAYS:      take = 1'b1;
         JMP_NO_REQ:      take = !status.req_valid;
         JMP_M_SMALL:     take = status.m_small;
         JMP_K_EQ_N:      take = status.k_eq_n;
         JMP_BUSY:        take = status.busy;
         JMP_ES_ZERO:     take = status.es_zero;
         JMP_ES_EVEN:     take = status.es_even;
         JMP_RSP_BLOCKED: take = status.rsp_blocked;
         default:         take = 1'b1;
      endcase
      step_in = take ? word.target : step_ff + 1'b1;
      op      = word.op;
      idle    = step_ff == STEP_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ----- rtl/modular_power_sum.sv -----
// The work per item grows with n = term count, with L = bit length of the exponent
// and with B = its count of one bits; n, L and B set how many modular products run.
// Each modular product runs in the serial multiplier, one bit per cycle over
// W = max(16, COUNT_WIDTH) multiplier bits; that unit sets the rate. One item at a time.
// Synchronous active-high reset: modulus returns to 49999, output beat is dropped.
// ----------------------------------------------------------------------------
// modular_power_sum
// Sum of k^p mod m for k = 1..n, microcoded over a serial modular multiplier.
// ----------------------------------------------------------------------------
module modular_power_sum #(
   parameter int COUNT_WIDTH    = mps_pkg::COUNT_WIDTH_DEFAULT,
   parameter int EXPONENT_WIDTH = mps_pkg::EXPONENT_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [mps_pkg::MOD_WIDTH-1:0] csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [COUNT_WIDTH-1:0]        req_term_count,
   input  logic [EXPONENT_WIDTH-1:0]     req_exponent,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mps_pkg::MOD_WIDTH-1:0] rsp_power_sum
);
   import mps_pkg::*;

   status_type status;
   op_type     op;
   logic       idle;

   mps_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .op     (op),
      .idle   (idle)
   );

   mps_datapath #(
      .COUNT_WIDTH    (COUNT_WIDTH),
      .EXPONENT_WIDTH (EXPONENT_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .op             (op),
      .idle           (idle),
      .status         (status),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_term_count (req_term_count),
      .req_exponent   (req_exponent),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_power_sum  (rsp_power_sum)
   );

   assign req_stall = !idle;

endmodule

// ----- rtl/mps_checker.sv -----
// ----------------------------------------------------------------------------
// mps_checker
// Port-level checks of the modular power sum, bound to the top level.
// ----------------------------------------------------------------------------
module mps_checker #(
   parameter int COUNT_WIDTH    = mps_pkg::COUNT_WIDTH_DEFAULT,
   parameter int EXPONENT_WIDTH = mps_pkg::EXPONENT_WIDTH_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          csr_we,
   input logic [mps_pkg::MOD_WIDTH-1:0] csr_wdata,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [COUNT_WIDTH-1:0]        req_term_count,
   input logic [EXPONENT_WIDTH-1:0]     req_exponent,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [mps_pkg::MOD_WIDTH-1:0] rsp_power_sum
);
   import mps_pkg::*;

   logic [MOD_WIDTH-1:0] modulus_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
      end else if (csr_we) begin
         modulus_ff <= csr_wdata;
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat survived reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_power_sum))
      else $error("stalled result beat changed");

   a_req_holds: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_term_count)
                                 && $stable(req_exponent))
      else $error("stalled request beat changed");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat taken while item in progress");

   a_sum_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (modulus_ff < MOD_WIDTH'(2) && rsp_power_sum == '0)
                 || (modulus_ff >= MOD_WIDTH'(2) && rsp_power_sum < modulus_ff))
      else $error("power sum not reduced by modulus");

endmodule

bind modular_power_sum mps_checker #(
   .COUNT_WIDTH    (COUNT_WIDTH),
   .EXPONENT_WIDTH (EXPONENT_WIDTH)
) u_mps_checker (.*);
